// ===== design/ncrm_pkg.sv =====
`timescale 1ns / 1ps
package ncrm_pkg;

	localparam int DATA_WIDTH_DEF = 48;
	localparam int FRAC_BITS_DEF  = 24;
	localparam int TOL_W          = 25;
	localparam int ITER_W         = 8;

	localparam logic [TOL_W-1:0]  TOL_RESET   = 25'd1;
	localparam logic [ITER_W-1:0] LIMIT_RESET = 8'd100;

	localparam logic REG_TOL   = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [1:0] ST_CONV    = 2'd0;
	localparam logic [1:0] ST_LIMIT   = 2'd1;
	localparam logic [1:0] ST_ZERO_DF = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_MUL_XX,
		OP_MUL_XXX,
		OP_MUL_3X,
		OP_MUL_3XX,
		OP_FX_A,
		OP_FX_B,
		OP_DFX,
		OP_DIV_D,
		OP_NEG,
		OP_UPD,
		OP_NUM,
		OP_DEN1,
		OP_DEN2,
		OP_DEN3,
		OP_MZERO,
		OP_DIV_M,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic dfx_zero;
		logic den_zero;
		logic cont;
		logic lim_hit;
	} sts_t;

endpackage

// ===== design/ncrm_div.sv =====
`timescale 1ns / 1ps
module ncrm_div #(
	parameter int DATA_WIDTH = 48,
	parameter int FRAC_BITS  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [DATA_WIDTH-1:0]          a_mag,
	input  logic [DATA_WIDTH-1:0]          b_mag,
	output logic                           done,
	output logic [DATA_WIDTH+FRAC_BITS-1:0] quo
);
	localparam int W  = DATA_WIDTH;
	localparam int QW = DATA_WIDTH + FRAC_BITS;
	localparam int CNT_W = $clog2(QW + 1);

	logic [W:0]       rem_q;
	logic [QW-1:0]    dv_q;
	logic [QW-1:0]    quo_q;
	logic [W-1:0]     b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       r2;
	logic             ge;

	assign r2   = {rem_q[W-1:0], dv_q[QW-1]};
	assign ge   = r2 >= {1'b0, b_q};
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dv_q  <= {a_mag, {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			b_q   <= b_mag;
		end else if (busy_q) begin
			rem_q <= ge ? (r2 - {1'b0, b_q}) : r2;
			quo_q <= {quo_q[QW-2:0], ge};
			dv_q  <= {dv_q[QW-2:0], 1'b0};
		end
	end

endmodule

// ===== design/ncrm_dp.sv =====
`timescale 1ns / 1ps
module ncrm_dp
	import ncrm_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [DATA_WIDTH-1:0] start_x,
	input  cmd_t                  cmd,
	input  logic [TOL_W-1:0]      tol,
	input  logic [ITER_W-1:0]     limit,
	output sts_t                  st,
	output logic [DATA_WIDTH-1:0] root_x,
	output logic [DATA_WIDTH-1:0] multiplicity,
	output logic                  mult_valid,
	output logic [ITER_W-1:0]     iterations,
	output logic [1:0]            status
);
	localparam int W     = DATA_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int NCH   = (W + 15) / 16;
	localparam int YW    = 16 * NCH;
	localparam int PW    = W + YW;
	localparam int QW    = W + F;
	localparam int XW    = (PW > QW) ? PW : QW;
	localparam int CW    = (W > TOL_W) ? W : TOL_W;
	localparam int MC_W  = $clog2(NCH + 1);
	localparam int KW    = W + F + 2;

	localparam logic [W-1:0]  MAXU = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [XW-1:0] MAXX = XW'(MAXU);
	localparam logic [KW-1:0] MAXK = KW'(MAXU);
	localparam logic [KW-1:0] K3   = KW'(3) << F;
	localparam logic [KW-1:0] K2   = KW'(2) << F;
	localparam logic [W-1:0]  THREE = (K3 > MAXK) ? MAXU : K3[W-1:0];
	localparam logic [W-1:0]  TWO   = (K2 > MAXK) ? MAXU : K2[W-1:0];

	typedef enum logic [1:0] {DST_XX, DST_T, DST_U, DST_V} dst_t;

	function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? MINV : MAXU;
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? MINV : MAXU;
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(input logic [W-1:0] a);
		return a[W-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic [W-1:0] sat_mag(input logic neg, input logic [XW-1:0] m);
		logic [W-1:0] lo;
		lo = m[W-1:0];
		if (!neg)
			return (m > MAXX) ? MAXU : lo;
		if (m > MAXX + 1'b1)
			return MINV;
		return ~lo + 1'b1;
	endfunction

	logic [W-1:0] x_q, x0_q, x1_q, x2_q, xx_q, t_q, u_q, v_q, d_q, m_q;
	logic         mv_q;
	logic [ITER_W-1:0] n_q;
	logic         done_q;

	logic [W-1:0]    mx_q;
	logic [YW-1:0]   my_q;
	logic [PW-1:0]   acc_q;
	logic [MC_W-1:0] mcnt_q;
	logic            mbusy_q;
	logic            mneg_q;
	dst_t            mdst_q;
	logic [W+15:0]   pp;
	logic [W-1:0]    mres;

	logic            dbusy_q;
	logic            dneg_q;
	logic            ddst_q;
	logic            div_start;
	logic [W-1:0]    div_a, div_b;
	logic            div_done;
	logic [QW-1:0]   div_quo;
	logic [W-1:0]    dres;

	logic            mul_start;
	logic [W-1:0]    mul_a, mul_b;
	dst_t            mul_dst;
	logic [W-1:0]    xsum;

	logic [W-1:0] root_q, mout_q;
	logic         mvout_q;
	logic [ITER_W-1:0] iter_q;
	logic [1:0]   stat_q;

	assign pp   = (W+16)'(mx_q) * (W+16)'(my_q[YW-1 -: 16]);
	assign mres = sat_mag(mneg_q, XW'(acc_q >> F));
	assign dres = sat_mag(dneg_q, XW'(div_quo));
	assign xsum = sadd(x_q, d_q);

	always_comb begin
		mul_start = 1'b1;
		mul_a     = x_q;
		mul_b     = x_q;
		mul_dst   = DST_XX;
		case (cmd.op)
			OP_MUL_XX: begin
				mul_dst = DST_XX;
			end
			OP_MUL_XXX: begin
				mul_a   = xx_q;
				mul_dst = DST_T;
			end
			OP_MUL_3X: begin
				mul_a   = THREE;
				mul_dst = DST_U;
			end
			OP_MUL_3XX: begin
				mul_a   = THREE;
				mul_b   = xx_q;
				mul_dst = DST_V;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign div_start = (cmd.op == OP_DIV_D) || (cmd.op == OP_DIV_M);
	assign div_a     = (cmd.op == OP_DIV_D) ? t_q : t_q;
	assign div_b     = v_q;

	ncrm_div #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.a_mag (mag(div_a)),
		.b_mag (mag(div_b)),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			mbusy_q <= 1'b0;
			dbusy_q <= 1'b0;
			mcnt_q  <= '0;
			n_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (load)
				n_q <= '0;
			if (mul_start) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= MC_W'(NCH);
			end else if (mbusy_q) begin
				if (mcnt_q == '0) begin
					mbusy_q <= 1'b0;
					done_q  <= 1'b1;
				end else begin
					mcnt_q <= mcnt_q - 1'b1;
				end
			end
			if (div_start)
				dbusy_q <= 1'b1;
			else if (dbusy_q && div_done) begin
				dbusy_q <= 1'b0;
				done_q  <= 1'b1;
			end
			case (cmd.op)
				OP_FX_A, OP_FX_B, OP_DFX, OP_NEG, OP_NUM, OP_DEN1, OP_DEN2,
				OP_DEN3, OP_MZERO: begin
					done_q <= 1'b1;
				end
				OP_UPD: begin
					done_q <= 1'b1;
					n_q    <= n_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q  <= start_x;
			x0_q <= start_x;
			x1_q <= start_x;
			x2_q <= start_x;
		end
		if (mul_start) begin
			mx_q   <= mag(mul_a);
			my_q   <= YW'(mag(mul_b)) << (YW - W);
			acc_q  <= '0;
			mneg_q <= mul_a[W-1] ^ mul_b[W-1];
			mdst_q <= mul_dst;
		end else if (mbusy_q) begin
			if (mcnt_q == '0) begin
				case (mdst_q)
					DST_XX: xx_q <= mres;
					DST_T:  t_q  <= mres;
					DST_U:  u_q  <= mres;
					DST_V:  v_q  <= mres;
					default: xx_q <= mres;
				endcase
			end else begin
				acc_q <= (acc_q << 16) + PW'(pp);
				my_q  <= my_q << 16;
			end
		end
		if (div_start) begin
			dneg_q <= div_a[W-1] ^ div_b[W-1];
			ddst_q <= (cmd.op == OP_DIV_M);
		end else if (dbusy_q && div_done) begin
			if (ddst_q) begin
				m_q  <= dres;
				mv_q <= 1'b1;
			end else begin
				d_q <= dres;
			end
		end
		case (cmd.op)
			OP_FX_A: t_q <= ssub(t_q, u_q);
			OP_FX_B: t_q <= ssub(t_q, TWO);
			OP_DFX:  v_q <= ssub(v_q, THREE);
			OP_NEG:  d_q <= ssub('0, d_q);
			OP_UPD: begin
				x_q  <= xsum;
				x0_q <= x1_q;
				x1_q <= x2_q;
				x2_q <= xsum;
			end
			OP_NUM:  t_q <= ssub(x0_q, x1_q);
			OP_DEN1: u_q <= sadd(x1_q, x1_q);
			OP_DEN2: v_q <= ssub(x0_q, u_q);
			OP_DEN3: v_q <= sadd(v_q, x2_q);
			OP_MZERO: begin
				m_q  <= '0;
				mv_q <= 1'b0;
			end
			OP_OUT: begin
				root_q  <= x_q;
				mout_q  <= m_q;
				mvout_q <= mv_q;
				iter_q  <= n_q;
				stat_q  <= cmd.code;
			end
			default: begin
			end
		endcase
	end

	assign st.done     = done_q;
	assign st.dfx_zero = (v_q == '0);
	assign st.den_zero = (v_q == '0);
	assign st.cont     = (CW'(mag(d_q)) > CW'(tol)) && (n_q < limit);
	assign st.lim_hit  = (n_q >= limit);

	assign root_x       = root_q;
	assign multiplicity = mout_q;
	assign mult_valid   = mvout_q;
	assign iterations   = iter_q;
	assign status       = stat_q;

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mbusy_q && dbusy_q))
		else $error("multiplier and divider busy together");

	a_load_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (n_q == '0))
		else $error("step count not cleared on load");

endmodule

// ===== design/ncrm_ctrl.sv =====
`timescale 1ns / 1ps
module ncrm_ctrl
	import ncrm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t st,
	output cmd_t cmd
);
	typedef enum logic [4:0] {
		S_IDLE, S_XX, S_XXX, S_3X, S_FXA, S_FXB, S_3XX, S_DFX, S_DIVD, S_NEG,
		S_UPD, S_NUM, S_DEN1, S_DEN2, S_DEN3, S_MZ, S_DIVM, S_FIN, S_OUTW
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	logic   issued_q;
	logic   zdf_q;
	logic   out_valid_q;
	op_t    op_cur;

	always_comb begin
		case (state_q)
			S_XX:    op_cur = OP_MUL_XX;
			S_XXX:   op_cur = OP_MUL_XXX;
			S_3X:    op_cur = OP_MUL_3X;
			S_FXA:   op_cur = OP_FX_A;
			S_FXB:   op_cur = OP_FX_B;
			S_3XX:   op_cur = OP_MUL_3XX;
			S_DFX:   op_cur = OP_DFX;
			S_DIVD:  op_cur = OP_DIV_D;
			S_NEG:   op_cur = OP_NEG;
			S_UPD:   op_cur = OP_UPD;
			S_NUM:   op_cur = OP_NUM;
			S_DEN1:  op_cur = OP_DEN1;
			S_DEN2:  op_cur = OP_DEN2;
			S_DEN3:  op_cur = OP_DEN3;
			S_MZ:    op_cur = OP_MZERO;
			S_DIVM:  op_cur = OP_DIV_M;
			default: op_cur = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '{op: OP_NONE, code: ST_CONV};
			issued_q    <= 1'b0;
			zdf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmd_q.op <= OP_NONE;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (op_cur != OP_NONE) begin
				if (!issued_q) begin
					cmd_q.op <= op_cur;
					issued_q <= 1'b1;
				end else if (st.done) begin
					issued_q <= 1'b0;
					case (state_q)
						S_XX:   state_q <= S_XXX;
						S_XXX:  state_q <= S_3X;
						S_3X:   state_q <= S_FXA;
						S_FXA:  state_q <= S_FXB;
						S_FXB:  state_q <= S_3XX;
						S_3XX:  state_q <= S_DFX;
						S_DFX: begin
							if (st.dfx_zero) begin
								zdf_q   <= 1'b1;
								state_q <= S_NUM;
							end else begin
								state_q <= S_DIVD;
							end
						end
						S_DIVD: state_q <= S_NEG;
						S_NEG:  state_q <= S_UPD;
						S_UPD:  state_q <= st.cont ? S_XX : S_NUM;
						S_NUM:  state_q <= S_DEN1;
						S_DEN1: state_q <= S_DEN2;
						S_DEN2: state_q <= S_DEN3;
						S_DEN3: state_q <= st.den_zero ? S_MZ : S_DIVM;
						default: state_q <= S_FIN;
					endcase
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							zdf_q   <= 1'b0;
							state_q <= S_XX;
						end
					end
					S_FIN: begin
						if (!out_valid_q || out_ready) begin
							cmd_q.op   <= OP_OUT;
							cmd_q.code <= zdf_q ? ST_ZERO_DF :
								(st.lim_hit ? ST_LIMIT : ST_CONV);
							state_q    <= S_OUTW;
						end
					end
					S_OUTW: begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd       = cmd_q;

	a_done_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		st.done |-> issued_q)
		else $error("datapath done without a pending command");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUTW) |-> !out_valid_q)
		else $error("result loaded over a pending transaction");

	a_out_cmd_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q.op == OP_OUT) |-> (state_q == S_OUTW))
		else $error("output load outside of output state");

endmodule

// ===== design/newton_cubic_root_multiplicity.sv =====
`timescale 1ns / 1ps
// Each Newton step runs four serial multiplies in 16-bit chunks, one restoring divide and five
// ALU ops; after the last step come the multiplicity tail and the output load.
// Throughput: one transaction at a time; the next is accepted after the result is loaded.
// Reset: arst_n clears control state; step_tolerance resets to 1, iteration_limit to 100.
module newton_cubic_root_multiplicity
	import ncrm_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] start_x,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] root_x,
	output logic [DATA_WIDTH-1:0] multiplicity,
	output logic                  mult_valid,
	output logic [ITER_W-1:0]     iterations,
	output logic [1:0]            status,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	logic [TOL_W-1:0]  tol_q;
	logic [ITER_W-1:0] limit_q;
	logic              in_acc;
	cmd_t              cmd;
	sts_t              st;

	assign pready = 1'b1;
	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RESET;
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_TOL)
				tol_q <= pwdata[TOL_W-1:0];
			else
				limit_q <= pwdata[ITER_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit_q) : 32'(tol_q);

	ncrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st       (st),
		.cmd      (cmd)
	);

	ncrm_dp #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (in_acc),
		.start_x     (start_x),
		.cmd         (cmd),
		.tol         (tol_q),
		.limit       (limit_q),
		.st          (st),
		.root_x      (root_x),
		.multiplicity(multiplicity),
		.mult_valid  (mult_valid),
		.iterations  (iterations),
		.status      (status)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import ncrm_pkg::*;

	localparam int W = 48;
	localparam int F = 24;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int HOLD_CYCLES = 12000;
	localparam longint MAXV = (64'sd1 <<< (W - 1)) - 1;
	localparam longint MINV = -(64'sd1 <<< (W - 1));

	typedef struct {
		logic [W-1:0]  root;
		logic [W-1:0]  mult;
		logic          mv;
		logic [7:0]    iters;
		logic [1:0]    st;
	} root_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [W-1:0] start_x = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [W-1:0] root_x;
	logic [W-1:0] multiplicity;
	logic mult_valid;
	logic [ITER_W-1:0] iterations;
	logic [1:0] status;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	root_result_t expected_roots[$];
	logic [TOL_W-1:0] tol_copy = TOL_RESET;
	logic [ITER_W-1:0] limit_copy = LIMIT_RESET;
	int fail_count = 0;
	bit idle_on = 1'b0;
	bit hold_req = 1'b0;
	int stall_count = 0;

	newton_cubic_root_multiplicity u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .start_x(start_x),
		.out_valid(out_valid), .out_ready(out_ready),
		.root_x(root_x), .multiplicity(multiplicity), .mult_valid(mult_valid),
		.iterations(iterations), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	function automatic longint sat_w(logic signed [129:0] v);
		if (v > MAXV) return MAXV;
		if (v < MINV) return MINV;
		return longint'(v[63:0]);
	endfunction

	function automatic longint fx_add(longint a, longint b);
		logic signed [129:0] ta, tb;
		ta = a;
		tb = b;
		return sat_w(ta + tb);
	endfunction

	function automatic longint fx_sub(longint a, longint b);
		logic signed [129:0] ta, tb;
		ta = a;
		tb = b;
		return sat_w(ta - tb);
	endfunction

	function automatic logic [127:0] abs128(longint a);
		logic signed [129:0] t;
		t = a;
		if (t < 0) t = -t;
		return t[127:0];
	endfunction

	function automatic longint signed_mag(bit neg, logic [127:0] m);
		logic signed [129:0] r;
		r = $signed({2'b00, m});
		if (neg) r = -r;
		return sat_w(r);
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return signed_mag((a < 0) != (b < 0), (abs128(a) * abs128(b)) >> F);
	endfunction

	function automatic longint fx_div(longint a, longint b);
		return signed_mag((a < 0) != (b < 0), (abs128(a) << F) / abs128(b));
	endfunction

	function automatic root_result_t predict_root(logic [W-1:0] raw);
		root_result_t r;
		longint three, two, x, x0, x1, x2, xx, fx, dfx, d, num, den, m;
		int n;
		bit zero_df;
		logic [127:0] dmag;
		three = longint'(3) <<< F;
		two = longint'(2) <<< F;
		x = longint'($signed(raw));
		x0 = x;
		x1 = x;
		x2 = x;
		n = 0;
		zero_df = 1'b0;
		m = 0;
		do begin
			xx = fx_mul(x, x);
			fx = fx_sub(fx_sub(fx_mul(xx, x), fx_mul(three, x)), two);
			dfx = fx_sub(fx_mul(three, xx), three);
			if (dfx == 0) begin
				zero_df = 1'b1;
				break;
			end
			d = fx_sub(0, fx_div(fx, dfx));
			x = fx_add(x, d);
			n++;
			x0 = x1;
			x1 = x2;
			x2 = x;
			dmag = abs128(d);
		end while (dmag > tol_copy && n < limit_copy);
		if (zero_df) r.st = ST_ZERO_DF;
		else if (n >= limit_copy) r.st = ST_LIMIT;
		else r.st = ST_CONV;
		num = fx_sub(x0, x1);
		den = fx_add(fx_sub(x0, fx_add(x1, x1)), x2);
		r.mv = (den != 0);
		if (den != 0) m = fx_div(num, den);
		r.root = x[W-1:0];
		r.mult = m[W-1:0];
		r.iters = n[7:0];
		return r;
	endfunction

	function automatic int draw_wait();
		if (!idle_on) return 0;
		return $urandom_range(0, 12);
	endfunction

	task automatic send_start(logic [W-1:0] x);
		int w;
		w = draw_wait();
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= x;
		do @(posedge clk); while (!in_ready);
		expected_roots.push_back(predict_root(x));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_roots.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_TOL) tol_copy = val[TOL_W-1:0];
		else limit_copy = val[ITER_W-1:0];
	endtask

	task automatic set_config(logic [TOL_W-1:0] tol, logic [ITER_W-1:0] lim);
		wait_idle();
		write_reg(REG_TOL, 32'(tol));
		write_reg(REG_LIMIT, 32'(lim));
	endtask

	function automatic logic [W-1:0] random_start();
		logic [63:0] v;
		longint s;
		int pick;
		pick = $urandom_range(0, 99);
		v = {$urandom, $urandom};
		s = longint'($signed(v[W-1:0]));
		if (pick < 15) return W'((longint'(2) <<< F) + $signed(v[15:0]));
		if (pick < 30) return W'(-(longint'(1) <<< F) + $signed(v[15:0]));
		if (pick < 40) return v[W-1:0];
		return W'(s >>> $urandom_range(0, 24));
	endfunction

	task automatic test_field_extremes();
		idle_on = 1'b0;
		send_start(W'(MAXV));
		send_start(W'(MINV));
		send_start('0);
		send_start(W'(1));
		send_start(W'(-1));
		send_start(W'(longint'(5) <<< F));
		send_start(W'(-(longint'(3) <<< F)));
		send_start(W'(48'h5555_5555_5555));
		send_start(W'(48'haaaa_aaaa_aaaa));
	endtask

	task automatic test_special_cases();
		send_start(W'(longint'(1) <<< F));
		send_start(W'(-(longint'(1) <<< F)));
		send_start(W'(longint'(2) <<< F));
		send_start(W'((longint'(2) <<< F) + 3));
		send_start(W'(-(longint'(1) <<< F) + 7));
	endtask

	task automatic test_config_extremes();
		set_config(TOL_W'(0), 8'd1);
		send_start(W'(longint'(7) <<< F));
		send_start(W'(longint'(2) <<< F));
		set_config(TOL_W'(25'd16777216), 8'd255);
		send_start(W'(MAXV));
		send_start(W'(-(longint'(1) <<< F) + 100));
		set_config(TOL_W'(0), 8'd255);
		send_start(W'(-(longint'(1) <<< F) + 3000));
		send_start(W'(longint'(9) <<< F));
	endtask

	task automatic test_random_starts();
		idle_on = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			set_config(TOL_W'($urandom_range(0, 4096)), ITER_W'($urandom_range(8, 100)));
			for (int i = 0; i < 25; i++) begin
				if (ph == 2) idle_on = (i >= 12);
				send_start(random_start());
			end
		end
	endtask

	task automatic test_output_backpressure();
		set_config(TOL_W'(256), 8'd40);
		hold_req = 1'b1;
		for (int i = 0; i < 5; i++) send_start(random_start());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_special_cases();
		test_config_extremes();
		test_random_starts();
		test_output_backpressure();
		wait_idle();
		repeat (300) @(posedge clk);
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				w = draw_wait();
				if (w > 0) begin
					out_ready <= 1'b0;
					repeat (w) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		root_result_t e;
		if (out_valid && out_ready) begin
			if (expected_roots.size() == 0) begin
				$error("unexpected result transaction");
				fail_count++;
			end else begin
				e = expected_roots.pop_front();
				if (root_x !== e.root) begin
					$error("root_x expected %h actual %h", e.root, root_x);
					fail_count++;
				end
				if (multiplicity !== e.mult) begin
					$error("multiplicity expected %h actual %h", e.mult, multiplicity);
					fail_count++;
				end
				if (mult_valid !== e.mv) begin
					$error("mult_valid expected %b actual %b", e.mv, mult_valid);
					fail_count++;
				end
				if (iterations !== e.iters) begin
					$error("iterations expected %0d actual %0d", e.iters, iterations);
					fail_count++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (psel && penable && pwrite) || !arst_n)
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
design/ncrm_pkg.sv
design/ncrm_div.sv
design/ncrm_dp.sv
design/ncrm_ctrl.sv
design/newton_cubic_root_multiplicity.sv
test/tb_top.sv
